// File: rtl/itoq_pkg.sv
package itoq_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 32;
   localparam int DEFAULT_TIME_WIDTH  = 16;

   localparam int REQ_W    = 3;
   localparam int ID_W     = 5;
   localparam int RID_W    = 6;
   localparam int COUNT_W  = 6;
   localparam int STATUS_W = 2;

   localparam logic [REQ_W-1:0] REQ_INSERT  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_OVERLAP = 3'd1;
   localparam logic [REQ_W-1:0] REQ_STAB    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SHOW    = 3'd3;
   localparam logic [REQ_W-1:0] REQ_ERASE   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_LIST    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   localparam logic [RID_W-1:0] RID_NONE = '1;

   typedef struct packed {
      logic capture;
      logic insert;
      logic erase;
      logic show_rd;
      logic show_out;
      logic scan_rd;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_at_end;
   } stat_type;

endpackage

// File: rtl/interval_table_overlap_query_top.sv
// Interval table with overlap and stabbing queries.
// Requests come in on start/busy: a request transfers at a rising edge with
// start high and busy low, carrying req_type and the req_ operand ports.
// Results leave on the rsp_ ports, each valid for one cycle while rsp_strobe
// is high; rsp_last marks the final result of a request. The receiver cannot
// stall, so every result is taken in the cycle it is shown.
// Insert and erase register their result straight after capture; show first
// reads the entry and then registers its result. Overlap count, stab and list
// all read the table memory one entry a cycle through its single read port;
// stab and list hold each match back until the next one is found, so that the
// final one can carry rsp_last, and overlap count gives only the final count.
// Busy stays high until the final result is registered, so the next request
// can transfer at the edge that takes that result.
// Unused request codes are taken and give no result.
// Reset clears all valid marks and the id counter; the stored bounds need no
// clearing since an entry's bounds are only used while it is valid.
module interval_table_overlap_query_top
   import itoq_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int TIME_WIDTH  = DEFAULT_TIME_WIDTH
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [REQ_W-1:0]             req_type,
   input  logic signed [TIME_WIDTH-1:0] req_start_time,
   input  logic signed [TIME_WIDTH-1:0] req_end_time,
   input  logic signed [TIME_WIDTH-1:0] req_at_time,
   input  logic [ID_W-1:0]              req_entry_id,
   output logic                         rsp_strobe,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic signed [RID_W-1:0]      rsp_result_id,
   output logic [COUNT_W-1:0]           rsp_match_count,
   output logic                         rsp_is_free,
   output logic signed [TIME_WIDTH-1:0] rsp_found_start,
   output logic signed [TIME_WIDTH-1:0] rsp_found_end,
   output logic                         rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   itoq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   itoq_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_WIDTH  (TIME_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_start_time  (req_start_time),
      .req_end_time    (req_end_time),
      .req_at_time     (req_at_time),
      .req_entry_id    (req_entry_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_result_id   (rsp_result_id),
      .rsp_match_count (rsp_match_count),
      .rsp_is_free     (rsp_is_free),
      .rsp_found_start (rsp_found_start),
      .rsp_found_end   (rsp_found_end),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/itoq_ctrl.sv
module itoq_ctrl
   import itoq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [REQ_W-1:0] req_type,
   input  stat_type         stat,
   output logic             busy,
   output cmd_type          cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_INSERT   = 3'd1;
   localparam logic [2:0] S_ERASE    = 3'd2;
   localparam logic [2:0] S_SHOW_RD  = 3'd3;
   localparam logic [2:0] S_SHOW_OUT = 3'd4;
   localparam logic [2:0] S_SCAN     = 3'd5;
   localparam logic [2:0] S_DRAIN    = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_INSERT:  state_in = S_INSERT;
                  REQ_ERASE:   state_in = S_ERASE;
                  REQ_SHOW:    state_in = S_SHOW_RD;
                  REQ_OVERLAP: state_in = S_SCAN;
                  REQ_STAB:    state_in = S_SCAN;
                  REQ_LIST:    state_in = S_SCAN;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_IDLE;
         end
         S_ERASE: begin
            cmd.erase = 1'b1;
            state_in  = S_IDLE;
         end
         S_SHOW_RD: begin
            cmd.show_rd = 1'b1;
            state_in    = S_SHOW_OUT;
         end
         S_SHOW_OUT: begin
            cmd.show_out = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (stat.scan_at_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // The last entry read is evaluated here.
            state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a start transfer");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |=> (state_ff == S_FINISH))
      else $error("scan did not finish after draining");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.insert, cmd.erase, cmd.show_out, cmd.finish}) <= 1)
      else $error("more than one result command at once");

endmodule

// File: rtl/itoq_dpath.sv
module itoq_dpath
   import itoq_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int TIME_WIDTH  = DEFAULT_TIME_WIDTH
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output stat_type                     stat,
   input  logic [REQ_W-1:0]             req_type,
   input  logic signed [TIME_WIDTH-1:0] req_start_time,
   input  logic signed [TIME_WIDTH-1:0] req_end_time,
   input  logic signed [TIME_WIDTH-1:0] req_at_time,
   input  logic [ID_W-1:0]              req_entry_id,
   output logic                         rsp_strobe,
   output logic [STATUS_W-1:0]          rsp_status,
   output logic signed [RID_W-1:0]      rsp_result_id,
   output logic [COUNT_W-1:0]           rsp_match_count,
   output logic                         rsp_is_free,
   output logic signed [TIME_WIDTH-1:0] rsp_found_start,
   output logic signed [TIME_WIDTH-1:0] rsp_found_end,
   output logic                         rsp_last
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // Captured request.
   logic [REQ_W-1:0]             type_ff;
   logic signed [TIME_WIDTH-1:0] start_ff;
   logic signed [TIME_WIDTH-1:0] end_ff;
   logic signed [TIME_WIDTH-1:0] at_ff;
   logic [ID_W-1:0]              id_ff;

   // Table state.
   logic [2*TIME_WIDTH-1:0] table_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic [TABLE_DEPTH-1:0]  valid_in;
   logic [CNT_W-1:0]        next_id_ff;
   logic [CNT_W-1:0]        next_id_in;

   // Read stage.
   logic [ADDR_W-1:0]       idx_ff;
   logic [ADDR_W-1:0]       rd_addr;
   logic [2*TIME_WIDTH-1:0] rd_data_ff;
   logic                    rd_valid_ff;
   logic [ADDR_W-1:0]       rd_idx_ff;
   logic                    eval_ff;

   // Scan accumulation.
   logic              pend_valid_ff;
   logic              pend_valid_in;
   logic [ADDR_W-1:0] pend_id_ff;
   logic [ADDR_W-1:0] pend_id_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   // Result registers.
   logic                         strobe_ff, strobe_in;
   logic [STATUS_W-1:0]          status_ff, status_in;
   logic [RID_W-1:0]             rid_ff, rid_in;
   logic [COUNT_W-1:0]           match_ff, match_in;
   logic                         free_ff, free_in;
   logic signed [TIME_WIDTH-1:0] fstart_ff, fstart_in;
   logic signed [TIME_WIDTH-1:0] fend_ff, fend_in;
   logic                         last_ff, last_in;

   logic                         id_in_range;
   logic [ADDR_W-1:0]            id_addr;
   logic                         id_live;
   logic                         ins_empty;
   logic                         ins_full;
   logic                         ins_ok;
   logic [ADDR_W-1:0]            ins_addr;
   logic signed [TIME_WIDTH-1:0] rd_start;
   logic signed [TIME_WIDTH-1:0] rd_end;
   logic                         overlap_hit;
   logic                         list_hit;

   assign id_in_range = (32'(id_ff) < TABLE_DEPTH);
   assign id_addr     = ADDR_W'(id_ff);
   assign id_live     = id_in_range && valid_ff[id_addr];
   assign ins_empty   = !(end_ff > start_ff);
   assign ins_full    = (next_id_ff == CNT_W'(TABLE_DEPTH));
   assign ins_ok      = !ins_empty && !ins_full;
   assign ins_addr    = ADDR_W'(next_id_ff);
   assign rd_addr     = cmd.show_rd ? id_addr : idx_ff;
   assign rd_start    = rd_data_ff[2*TIME_WIDTH-1:TIME_WIDTH];
   assign rd_end      = rd_data_ff[TIME_WIDTH-1:0];

   assign overlap_hit = rd_valid_ff && (rd_start < end_ff) && (rd_end > start_ff);
   assign list_hit    = rd_valid_ff &&
                        ((type_ff == REQ_LIST) || ((rd_start <= at_ff) && (at_ff < rd_end)));

   assign stat.scan_at_end = (idx_ff == ADDR_W'(TABLE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (cmd.insert && ins_ok) begin
         table_mem[ins_addr] <= {start_ff, end_ff};
      end
      if (cmd.show_rd || cmd.scan_rd) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      next_id_in    = next_id_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      count_in      = count_ff;
      strobe_in     = 1'b0;
      status_in     = ST_OK;
      rid_in        = '0;
      match_in      = '0;
      free_in       = 1'b0;
      fstart_in     = '0;
      fend_in       = '0;
      last_in       = 1'b0;

      if (cmd.capture) begin
         pend_valid_in = 1'b0;
         count_in      = '0;
      end

      if (cmd.insert) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
         if (ins_empty) begin
            status_in = ST_EMPTY;
            rid_in    = RID_W'(next_id_ff) - RID_W'(1);
         end else if (ins_full) begin
            status_in = ST_FULL;
            rid_in    = RID_W'(next_id_ff) - RID_W'(1);
         end else begin
            rid_in             = RID_W'(next_id_ff);
            valid_in[ins_addr] = 1'b1;
            next_id_in         = next_id_ff + CNT_W'(1);
         end
      end

      if (cmd.erase) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
         rid_in    = RID_W'(id_ff);
         if (id_live) begin
            valid_in[id_addr] = 1'b0;
         end else begin
            status_in = ST_NOTFOUND;
         end
      end

      if (cmd.show_out) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
         rid_in    = RID_W'(id_ff);
         if (id_live) begin
            fstart_in = rd_start;
            fend_in   = rd_end;
         end else begin
            status_in = ST_NOTFOUND;
         end
      end

      if (eval_ff) begin
         if (type_ff == REQ_OVERLAP) begin
            if (overlap_hit) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (list_hit) begin
            // A match is held back one step so that the final one can carry last.
            if (pend_valid_ff) begin
               strobe_in = 1'b1;
               rid_in    = RID_W'(pend_id_ff);
            end
            pend_valid_in = 1'b1;
            pend_id_in    = rd_idx_ff;
         end
      end

      if (cmd.finish) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
         if (type_ff == REQ_OVERLAP) begin
            match_in = COUNT_W'(count_ff);
            free_in  = (count_ff == '0);
         end else if (pend_valid_ff) begin
            rid_in = RID_W'(pend_id_ff);
         end else begin
            status_in = ST_NOTFOUND;
            rid_in    = RID_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         next_id_ff    <= '0;
         eval_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         next_id_ff    <= next_id_in;
         eval_ff       <= cmd.scan_rd;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         start_ff <= req_start_time;
         end_ff   <= req_end_time;
         at_ff    <= req_at_time;
         id_ff    <= req_entry_id;
         idx_ff   <= '0;
      end else if (cmd.scan_rd) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
      if (cmd.scan_rd) begin
         rd_valid_ff <= valid_ff[idx_ff];
         rd_idx_ff   <= idx_ff;
      end
      pend_id_ff <= pend_id_in;
      count_ff   <= count_in;
      status_ff  <= status_in;
      rid_ff     <= rid_in;
      match_ff   <= match_in;
      free_ff    <= free_in;
      fstart_ff  <= fstart_in;
      fend_ff    <= fend_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_id   = rid_ff;
   assign rsp_match_count = match_ff;
   assign rsp_is_free     = free_ff;
   assign rsp_found_start = fstart_ff;
   assign rsp_found_end   = fend_ff;
   assign rsp_last        = last_ff;

   a_next_id_bound: assert property (@(posedge clock) disable iff (reset)
      next_id_ff <= CNT_W'(TABLE_DEPTH))
      else $error("issued id count ran past the table depth");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |=> !strobe_ff)
      else $error("result transfer directly after a final result");

   a_free_means_zero: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && free_ff) |-> (match_ff == '0 && last_ff))
      else $error("free flag with a non-zero count");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && status_ff == ST_NOTFOUND && rid_ff == RID_NONE) |-> last_ff)
      else $error("empty-list result not marked last");

endmodule
